FILE: rtl/egmt_pkg.sv
// ----------------------------------------------------------------------------
// egmt_pkg
// Types, codes and defaults shared by the ECMP group member table modules.
// ----------------------------------------------------------------------------
package egmt_pkg;

  localparam int DEF_MAX_MEMBERS = 8;
  localparam int DEF_HOP_BITS    = 16;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_UPDATE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ALREADY     = 3'd1;
  localparam logic [2:0] ST_NOT_PRESENT = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_IF_MISSING  = 3'd4;

  localparam logic [3:0] REFS_MAX = 4'd15;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] next_hop_id;
    logic        member_unresolved;
    logic [15:0] interface_id;
  } in_word_t;

  typedef struct packed {
    logic        is_slot_write;
    logic [2:0]  slot_index;
    logic [15:0] slot_next_hop;
    logic        last;
    logic [2:0]  status;
    logic [3:0]  member_total;
    logic [15:0] first_member;
    logic [3:0]  interface_total;
    logic        interface_list_changed;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MSCAN, S_MDEC, S_IFSCAN, S_IFDEC, S_IFMOVE,
    S_RSINIT, S_RS1, S_RS2, S_FINAL
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MSCAN, OP_SETST, OP_ADD, OP_REMOVE, OP_UPDATE,
    OP_CLEAR, OP_IFSCAN, OP_IFADD, OP_IFREM, OP_IFMOVE, OP_RSINIT,
    OP_RS1, OP_RS2INIT, OP_RS2, OP_FINAL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       track;
    logic       m_hit;
    logic       m_end;
    logic       found;
    logic       full;
    logic       if_hit;
    logic       if_end;
    logic       if_move;
  } sts_t;

endpackage

FILE: rtl/egmt_ctrl.sv
// ----------------------------------------------------------------------------
// egmt_ctrl
// Sequencer that steps the datapath through search, update and resync.
// ----------------------------------------------------------------------------
module egmt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output egmt_pkg::cmd_t cmd,
  input  egmt_pkg::sts_t sts
);
  import egmt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = OP_NONE;
    cmd.status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MSCAN;
        end
      end
      S_MSCAN: begin
        cmd.op = OP_MSCAN;
        if (sts.m_hit || sts.m_end) state_nxt = S_MDEC;
      end
      S_MDEC: begin
        case (sts.mode)
          MODE_ADD: begin
            if (sts.found) begin
              cmd.op = OP_SETST; cmd.status = ST_ALREADY; state_nxt = S_FINAL;
            end else if (sts.full) begin
              cmd.op = OP_SETST; cmd.status = ST_FULL; state_nxt = S_FINAL;
            end else begin
              cmd.op    = OP_ADD;
              state_nxt = sts.track ? S_IFSCAN : S_RSINIT;
            end
          end
          MODE_REMOVE: begin
            if (!sts.found) begin
              cmd.op = OP_SETST; cmd.status = ST_NOT_PRESENT; state_nxt = S_FINAL;
            end else begin
              cmd.op    = OP_REMOVE;
              state_nxt = sts.track ? S_IFSCAN : S_RSINIT;
            end
          end
          MODE_UPDATE: begin
            if (!sts.found) begin
              cmd.op = OP_SETST; cmd.status = ST_NOT_PRESENT; state_nxt = S_FINAL;
            end else begin
              cmd.op    = OP_UPDATE;
              state_nxt = S_RSINIT;
            end
          end
          default: begin
            cmd.op    = OP_CLEAR;
            state_nxt = S_FINAL;
          end
        endcase
      end
      S_IFSCAN: begin
        cmd.op = OP_IFSCAN;
        if (sts.if_hit || sts.if_end) state_nxt = S_IFDEC;
      end
      S_IFDEC: begin
        if (sts.mode == MODE_ADD) begin
          cmd.op    = OP_IFADD;
          state_nxt = S_RSINIT;
        end else begin
          cmd.op    = OP_IFREM;
          state_nxt = sts.if_move ? S_IFMOVE : S_RSINIT;
        end
      end
      S_IFMOVE: begin
        cmd.op    = OP_IFMOVE;
        state_nxt = S_RSINIT;
      end
      S_RSINIT: begin
        cmd.op    = OP_RSINIT;
        state_nxt = S_RS1;
      end
      S_RS1: begin
        if (sts.m_end) begin
          cmd.op    = OP_RS2INIT;
          state_nxt = S_RS2;
        end else begin
          cmd.op = OP_RS1;
        end
      end
      S_RS2: begin
        if (sts.m_end) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.op = OP_RS2;
        end
      end
      S_FINAL: begin
        cmd.op    = OP_FINAL;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/egmt_dp.sv
// ----------------------------------------------------------------------------
// egmt_dp
// Member, slot and interface storage with the search and resync datapath.
// ----------------------------------------------------------------------------
module egmt_dp #(
  parameter int MAX_MEMBERS = egmt_pkg::DEF_MAX_MEMBERS,
  parameter int HOP_BITS    = egmt_pkg::DEF_HOP_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  egmt_pkg::in_word_t  in_word,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  egmt_pkg::cmd_t      cmd,
  output egmt_pkg::sts_t      sts,
  output logic                out_valid,
  output egmt_pkg::out_word_t out_word
);
  import egmt_pkg::*;

  localparam int IW = $clog2(MAX_MEMBERS);
  localparam int CW = $clog2(MAX_MEMBERS + 1);

  logic [HOP_BITS-1:0] hop_r    [MAX_MEMBERS];
  logic                pend_r   [MAX_MEMBERS];
  logic [HOP_BITS-1:0] shop_r   [MAX_MEMBERS];
  logic [MAX_MEMBERS-1:0] sprog_r;
  logic [IW-1:0]       useful_r [MAX_MEMBERS];
  logic [15:0]         ikey_r   [MAX_MEMBERS];
  logic [3:0]          irefs_r  [MAX_MEMBERS];

  logic [CW-1:0]       cnt_r, icnt_r, idx_r, jidx_r, nu_r;
  logic [IW-1:0]       pos_r, jpos_r, rr_r;
  logic                track_r, found_r, jfound_r, pend_in_r, chg_r;
  logic [1:0]          mode_r;
  logic [HOP_BITS-1:0] key_r;
  logic [15:0]         ifc_r;
  logic [2:0]          st_r;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  logic [IW-1:0]       hop_addr, pend_addr, if_addr, last_idx, cur;
  logic [HOP_BITS-1:0] hop_rd;
  logic                pend_rd;
  logic [15:0]         ikey_rd;
  logic [3:0]          irefs_rd;
  logic                want, sset;
  out_word_t           fin_word, slot_word;

  assign last_idx = IW'(cnt_r - CW'(1));
  assign cur      = idx_r[IW-1:0];

  always_comb begin
    hop_addr  = cur;
    pend_addr = cur;
    if (cmd.op == OP_REMOVE) begin
      hop_addr  = last_idx;
      pend_addr = last_idx;
    end else if (cmd.op == OP_RS2 && nu_r != '0) begin
      hop_addr = useful_r[rr_r];
    end
  end

  always_comb begin
    case (cmd.op)
      OP_IFSCAN: if_addr = jidx_r[IW-1:0];
      OP_IFMOVE: if_addr = icnt_r[IW-1:0];
      default:   if_addr = jpos_r;
    endcase
  end

  assign hop_rd   = hop_r[hop_addr];
  assign pend_rd  = pend_r[pend_addr];
  assign ikey_rd  = ikey_r[if_addr];
  assign irefs_rd = irefs_r[if_addr];

  assign sts.mode    = mode_r;
  assign sts.track   = track_r;
  assign sts.m_end   = (idx_r >= cnt_r);
  assign sts.m_hit   = !sts.m_end && (hop_rd == key_r);
  assign sts.found   = found_r;
  assign sts.full    = (cnt_r >= CW'(MAX_MEMBERS));
  assign sts.if_end  = (jidx_r >= icnt_r);
  assign sts.if_hit  = !sts.if_end && (ikey_rd == ifc_r);
  assign sts.if_move = jfound_r && (irefs_rd <= 4'd1);

  assign want = !sts.m_end &&
                (((cmd.op == OP_RS1) && !pend_rd) ||
                 ((cmd.op == OP_RS2) && ((nu_r == '0) || pend_rd)));
  assign sset = want && (!sprog_r[cur] || (shop_r[cur] != hop_rd));

  always_comb begin
    slot_word               = '0;
    slot_word.is_slot_write = 1'b1;
    slot_word.slot_index    = 3'(cur);
    slot_word.slot_next_hop = 16'(hop_rd);
    fin_word                        = '0;
    fin_word.last                   = 1'b1;
    fin_word.status                 = st_r;
    fin_word.member_total           = 4'(cnt_r);
    fin_word.first_member           = (cnt_r == CW'(1)) ? 16'(hop_r[0]) : 16'd0;
    fin_word.interface_total        = 4'(icnt_r);
    fin_word.interface_list_changed = chg_r;
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    if (cmd.op == OP_FINAL) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = fin_word;
    end else if (sset) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = slot_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      icnt_r      <= '0;
      sprog_r     <= '0;
      track_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) track_r <= cfg_wdata;
      out_valid_r <= out_valid_nxt;
      out_word_r  <= out_word_nxt;
      case (cmd.op)
        OP_LOAD: begin
          mode_r    <= in_word.mode;
          key_r     <= HOP_BITS'(in_word.next_hop_id);
          pend_in_r <= in_word.member_unresolved;
          ifc_r     <= in_word.interface_id;
          idx_r     <= '0;
          jidx_r    <= '0;
          found_r   <= 1'b0;
          jfound_r  <= 1'b0;
          st_r      <= ST_OK;
          chg_r     <= 1'b0;
        end
        OP_MSCAN: begin
          if (sts.m_hit) begin
            found_r <= 1'b1;
            pos_r   <= cur;
          end else if (!sts.m_end) begin
            idx_r <= idx_r + CW'(1);
          end
        end
        OP_SETST: st_r <= cmd.status;
        OP_ADD: begin
          hop_r[cnt_r[IW-1:0]]   <= key_r;
          pend_r[cnt_r[IW-1:0]]  <= pend_in_r;
          sprog_r[cnt_r[IW-1:0]] <= 1'b0;
          cnt_r                  <= cnt_r + CW'(1);
        end
        OP_REMOVE: begin
          hop_r[pos_r]  <= hop_rd;
          pend_r[pos_r] <= pend_rd;
          cnt_r         <= cnt_r - CW'(1);
        end
        OP_UPDATE: begin
          pend_r[pos_r]  <= pend_in_r;
          sprog_r[pos_r] <= 1'b0;
        end
        OP_CLEAR: begin
          chg_r   <= (icnt_r != '0);
          cnt_r   <= '0;
          icnt_r  <= '0;
          sprog_r <= '0;
        end
        OP_IFSCAN: begin
          if (sts.if_hit) begin
            jfound_r <= 1'b1;
            jpos_r   <= jidx_r[IW-1:0];
          end else if (!sts.if_end) begin
            jidx_r <= jidx_r + CW'(1);
          end
        end
        OP_IFADD: begin
          if (jfound_r) begin
            if (irefs_rd != REFS_MAX) irefs_r[jpos_r] <= irefs_rd + 4'd1;
          end else if (icnt_r < CW'(MAX_MEMBERS)) begin
            ikey_r[icnt_r[IW-1:0]]  <= ifc_r;
            irefs_r[icnt_r[IW-1:0]] <= 4'd1;
            icnt_r                  <= icnt_r + CW'(1);
            chg_r                   <= 1'b1;
          end
        end
        OP_IFREM: begin
          if (!jfound_r) begin
            st_r <= ST_IF_MISSING;
          end else if (irefs_rd > 4'd1) begin
            irefs_r[jpos_r] <= irefs_rd - 4'd1;
          end else begin
            icnt_r <= icnt_r - CW'(1);
            chg_r  <= 1'b1;
          end
        end
        OP_IFMOVE: begin
          ikey_r[jpos_r]  <= ikey_rd;
          irefs_r[jpos_r] <= irefs_rd;
        end
        OP_RSINIT: begin
          idx_r <= '0;
          nu_r  <= '0;
          rr_r  <= '0;
        end
        OP_RS1: begin
          if (!sts.m_end) begin
            if (!pend_rd) begin
              useful_r[nu_r[IW-1:0]] <= cur;
              nu_r                   <= nu_r + CW'(1);
            end
            idx_r <= idx_r + CW'(1);
          end
        end
        OP_RS2INIT: idx_r <= '0;
        OP_RS2: begin
          if (!sts.m_end) begin
            if ((nu_r != '0) && pend_rd) begin
              rr_r <= ((CW'(rr_r) + CW'(1)) == nu_r) ? '0 : rr_r + IW'(1);
            end
            idx_r <= idx_r + CW'(1);
          end
        end
        default: ;
      endcase
      if (sset) begin
        shop_r[cur]  <= hop_rd;
        sprog_r[cur] <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: rtl/ecmp_group_member_table.sv
// ----------------------------------------------------------------------------
// ecmp_group_member_table
// One ECMP group: member list, forwarding slots and interface records.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the cycle in which the final word of that command is shown. Slot
// writes come out at most one per cycle, each for one cycle on out_valid,
// followed by one final word with last set. The receiver cannot hold results
// off and must take every word in the cycle it is shown. An add or a remove
// runs the member search, then, when interface tracking is on, the interface
// search and record update, with an extra move step when an interface record
// is removed, then two resync passes over the members. An update skips the
// interface step; a clear or a rejected command runs only the member search.
// The searches and resync passes walk the entries one entry per cycle.
module ecmp_group_member_table #(
  parameter int MAX_MEMBERS = egmt_pkg::DEF_MAX_MEMBERS,
  parameter int HOP_BITS    = egmt_pkg::DEF_HOP_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  egmt_pkg::in_word_t  in_word,
  output logic                out_valid,
  output egmt_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import egmt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  egmt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  egmt_dp #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .HOP_BITS    (HOP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

FILE: rtl/egmt_chk.sv
// ----------------------------------------------------------------------------
// egmt_chk
// Port-level checks on command and result sequencing.
// ----------------------------------------------------------------------------
module egmt_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input egmt_pkg::out_word_t out_word
);
  import egmt_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted command");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |-> !busy)
    else $error("final word shown while still busy");

  a_slot_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.is_slot_write |-> busy && !out_word.last)
    else $error("slot write outside a command");

  a_word_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.last != out_word.is_slot_write))
    else $error("word is neither a slot write nor a final word");

endmodule

bind ecmp_group_member_table egmt_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

FILE: tb/ecmp_group_checker.sv
// ----------------------------------------------------------------------------
// ecmp_group_checker
// Watches the command and result words of the ECMP group member table,
// predicts the slot writes and final status of each command and compares.
// ----------------------------------------------------------------------------
module ecmp_group_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  egmt_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  egmt_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  output int                  fail_count,
  output int                  pending_words
);
  import egmt_pkg::*;

  localparam int NMEM = DEF_MAX_MEMBERS;

  logic        track;
  logic [15:0] mem_hop [NMEM];
  logic        mem_pend [NMEM];
  logic [15:0] slot_hop [NMEM];
  logic        slot_set [NMEM];
  int          mem_cnt;
  logic [15:0] if_key [NMEM];
  logic [3:0]  if_refs [NMEM];
  int          if_cnt;
  out_word_t   expected_words [$];

  assign pending_words = expected_words.size();

  function automatic out_word_t final_word(logic [2:0] st, logic chg);
    out_word_t w;
    w = '0;
    w.last = 1'b1;
    w.status = st;
    w.member_total = mem_cnt[3:0];
    w.first_member = (mem_cnt == 1) ? mem_hop[0] : 16'd0;
    w.interface_total = if_cnt[3:0];
    w.interface_list_changed = chg;
    return w;
  endfunction

  task automatic program_slot(int i, logic [15:0] hop);
    out_word_t w;
    if (!slot_set[i] || slot_hop[i] != hop) begin
      slot_hop[i] = hop;
      slot_set[i] = 1'b1;
      w = '0;
      w.is_slot_write = 1'b1;
      w.slot_index = i[2:0];
      w.slot_next_hop = hop;
      expected_words.push_back(w);
    end
  endtask

  task automatic resync_slots();
    int resolved [NMEM];
    int nres;
    int rr;
    nres = 0;
    rr = 0;
    for (int i = 0; i < mem_cnt; i++) begin
      if (!mem_pend[i]) begin
        resolved[nres] = i;
        nres++;
        program_slot(i, mem_hop[i]);
      end
    end
    for (int i = 0; i < mem_cnt; i++) begin
      if (nres == 0) begin
        program_slot(i, mem_hop[i]);
      end else if (mem_pend[i]) begin
        program_slot(i, mem_hop[resolved[rr]]);
        rr = (rr + 1 >= nres) ? 0 : rr + 1;
      end
    end
  endtask

  task automatic apply_command(in_word_t c);
    logic [2:0] st;
    logic       chg;
    int         pos;
    int         j;
    st = ST_OK;
    chg = 1'b0;
    pos = mem_cnt;
    j = if_cnt;
    for (int i = 0; i < mem_cnt; i++) begin
      if (pos == mem_cnt && mem_hop[i] == c.next_hop_id) pos = i;
    end
    for (int i = 0; i < if_cnt; i++) begin
      if (j == if_cnt && if_key[i] == c.interface_id) j = i;
    end
    case (c.mode)
      MODE_ADD: begin
        if (pos < mem_cnt) begin
          st = ST_ALREADY;
        end else if (mem_cnt >= NMEM) begin
          st = ST_FULL;
        end else begin
          mem_hop[mem_cnt] = c.next_hop_id;
          mem_pend[mem_cnt] = c.member_unresolved;
          slot_set[mem_cnt] = 1'b0;
          if (track) begin
            if (j < if_cnt) begin
              if (if_refs[j] < REFS_MAX) if_refs[j]++;
            end else if (if_cnt < NMEM) begin
              if_key[if_cnt] = c.interface_id;
              if_refs[if_cnt] = 4'd1;
              if_cnt++;
              chg = 1'b1;
            end
          end
          mem_cnt++;
          resync_slots();
        end
      end
      MODE_REMOVE: begin
        if (pos >= mem_cnt) begin
          st = ST_NOT_PRESENT;
        end else begin
          mem_cnt--;
          mem_hop[pos] = mem_hop[mem_cnt];
          mem_pend[pos] = mem_pend[mem_cnt];
          if (track) begin
            if (j >= if_cnt) begin
              st = ST_IF_MISSING;
            end else if (if_refs[j] > 4'd1) begin
              if_refs[j]--;
            end else begin
              if_cnt--;
              if_key[j] = if_key[if_cnt];
              if_refs[j] = if_refs[if_cnt];
              chg = 1'b1;
            end
          end
          resync_slots();
        end
      end
      MODE_UPDATE: begin
        if (pos >= mem_cnt) begin
          st = ST_NOT_PRESENT;
        end else begin
          mem_pend[pos] = c.member_unresolved;
          slot_set[pos] = 1'b0;
          resync_slots();
        end
      end
      default: begin
        chg = (if_cnt > 0);
        mem_cnt = 0;
        if_cnt = 0;
        for (int i = 0; i < NMEM; i++) slot_set[i] = 1'b0;
      end
    endcase
    expected_words.push_back(final_word(st, chg));
  endtask

  task automatic compare_word(out_word_t got);
    out_word_t e;
    if (expected_words.size() == 0) begin
      $error("unexpected result word %h", got);
      fail_count++;
      return;
    end
    e = expected_words.pop_front();
    if (got.is_slot_write !== e.is_slot_write) begin
      $error("is_slot_write exp %0h got %0h", e.is_slot_write, got.is_slot_write);
      fail_count++;
    end
    if (got.slot_index !== e.slot_index) begin
      $error("slot_index exp %0h got %0h", e.slot_index, got.slot_index);
      fail_count++;
    end
    if (got.slot_next_hop !== e.slot_next_hop) begin
      $error("slot_next_hop exp %0h got %0h", e.slot_next_hop, got.slot_next_hop);
      fail_count++;
    end
    if (got.last !== e.last) begin
      $error("last exp %0h got %0h", e.last, got.last);
      fail_count++;
    end
    if (got.status !== e.status) begin
      $error("status exp %0h got %0h", e.status, got.status);
      fail_count++;
    end
    if (got.member_total !== e.member_total) begin
      $error("member_total exp %0h got %0h", e.member_total, got.member_total);
      fail_count++;
    end
    if (got.first_member !== e.first_member) begin
      $error("first_member exp %0h got %0h", e.first_member, got.first_member);
      fail_count++;
    end
    if (got.interface_total !== e.interface_total) begin
      $error("interface_total exp %0h got %0h", e.interface_total, got.interface_total);
      fail_count++;
    end
    if (got.interface_list_changed !== e.interface_list_changed) begin
      $error("interface_list_changed exp %0h got %0h", e.interface_list_changed,
             got.interface_list_changed);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      track = 1'b0;
      mem_cnt = 0;
      if_cnt = 0;
      for (int i = 0; i < NMEM; i++) begin
        slot_set[i] = 1'b0;
        slot_hop[i] = '0;
        if_key[i] = '0;
        if_refs[i] = '0;
      end
      expected_words.delete();
    end else begin
      if (out_valid) compare_word(out_word);
      if (cfg_we) track = cfg_wdata;
      if (start && !busy) apply_command(in_word);
    end
  end
endmodule

FILE: tb/tb_ecmp_group_member_table.sv
// ----------------------------------------------------------------------------
// tb_ecmp_group_member_table
// Drives directed and random member commands into the ECMP group member
// table under both interface tracking settings and reports the verdict.
// ----------------------------------------------------------------------------
module tb_ecmp_group_member_table;
  import egmt_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  int        fail_count;
  int        pending_words;
  bit        allow_gaps = 1'b1;
  logic [15:0] hop_pool [6];
  logic [15:0] if_pool [4];

  always #5 clk = ~clk;

  ecmp_group_member_table DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  ecmp_group_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending_words(pending_words)
  );

  task automatic send(logic [1:0] m, logic [15:0] hop, logic unres, logic [15:0] ifc);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= '{mode: m, next_hop_id: hop, member_unresolved: unres, interface_id: ifc};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_words != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_tracking(logic v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    logic [1:0] m;
    int r;
    for (int k = 0; k < n; k++) begin
      if (k > n - 20) allow_gaps = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 45) m = MODE_ADD;
      else if (r < 70) m = MODE_REMOVE;
      else if (r < 95) m = MODE_UPDATE;
      else m = MODE_CLEAR;
      if ($urandom_range(0, 9) == 0) begin
        send(m, 16'($urandom), 1'($urandom), 16'($urandom));
      end else begin
        send(m, hop_pool[$urandom_range(0, 5)] ^ 16'($urandom_range(0, 7)),
             1'($urandom), if_pool[$urandom_range(0, 3)]);
      end
    end
    allow_gaps = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(MODE_ADD, 16'h0000, 1'b0, 16'h0000);
    send(MODE_ADD, 16'hFFFF, 1'b1, 16'hFFFF);
    send(MODE_ADD, 16'h0000, 1'b0, 16'h0000);
    send(MODE_UPDATE, 16'h0000, 1'b1, 16'h0000);
    send(MODE_UPDATE, 16'h1234, 1'b0, 16'h0000);
    send(MODE_REMOVE, 16'h1234, 1'b0, 16'h0000);
    send(MODE_REMOVE, 16'h0000, 1'b0, 16'h0000);
    send(MODE_CLEAR, 16'h0000, 1'b0, 16'h0000);
    set_tracking(1'b1);
    for (int i = 0; i < 9; i++) send(MODE_ADD, 16'(i + 1), 1'(i % 3 == 0), 16'(i));
    send(MODE_REMOVE, 16'd2, 1'b0, 16'hBEEF);
    send(MODE_REMOVE, 16'd3, 1'b0, 16'd2);
    send(MODE_CLEAR, 16'h0000, 1'b0, 16'h0000);
    for (int i = 0; i < 17; i++) send(MODE_ADD, 16'(i + 16'h100), 1'b0, 16'h00AA);
    drain();
    send(MODE_CLEAR, 16'h0000, 1'b0, 16'h0000);
    for (int i = 0; i < 6; i++) hop_pool[i] = 16'($urandom);
    for (int i = 0; i < 4; i++) if_pool[i] = 16'($urandom);
    random_phase(70);
    set_tracking(1'b0);
    random_phase(40);
    set_tracking(1'b1);
    random_phase(30);
    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
